/* design/packet_decimate_drift_align_top_assert.svh */
// assertion macros for the packet decimator top level
`ifndef PACKET_DECIMATE_DRIFT_ALIGN_TOP_ASSERT_SVH
`define PACKET_DECIMATE_DRIFT_ALIGN_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PDDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define PDDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pdda_pkg.sv */
// shared types and constants of the packet decimator
`default_nettype none
package pdda_pkg;
    localparam int MAX_CHANNELS_DEF = 32;
    localparam int SAMPLE_W         = 16;
    localparam int CHAN_W           = 5;
    localparam int COL_W            = 32;
    localparam int CFG_W            = 32;
    localparam int CFG_IDX_W        = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDED_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LIMIT  = 3'd4;

    // what happens to the current packet
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_EMIT  = 2'd1,
        ACT_TWICE = 2'd2
    } t_action;
endpackage
`default_nettype wire

/* design/pdda_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module pdda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* design/packet_decimate_drift_align_top.sv */
// top level of the packet decimator with periodic drop or repeat correction
// a kept sample appears on the output register in the cycle after its input transfer
// throughput: one input sample per cycle while no replay runs and the output is taken
// replay of a repeated packet: each sample takes a ram read, then an output load, through
//   the one read port of the replay ram; input is stalled while the replay runs
// reset (synchronous, active low) clears counters and output valid and sets config to defaults;
//   the replay ram is not cleared, entries are always written before a replay reads them
`default_nettype none
module packet_decimate_drift_align_top #(
    parameter int MAX_CHANNELS = pdda_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input sample channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [pdda_pkg::SAMPLE_W-1:0]  i_sample_in,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pdda_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic        [pdda_pkg::CHAN_W-1:0]    o_channel_out,
    output logic        [pdda_pkg::COL_W-1:0]     o_column_out,
    output logic                                  o_column_end,
    output logic                                  o_repeated,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic        [pdda_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [pdda_pkg::CFG_W-1:0]     i_cfg_data
);
    import pdda_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [5:0] MAX_N = 6'(MAX_CHANNELS);

    // run: taking input; read: issue replay ram read; load: move read data to output
    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_LOAD
    } t_state;

    // configuration registers
    logic [5:0]          r_num_ch;
    logic [15:0]         r_skip;
    logic [31:0]         r_gap;
    logic [16:0]         r_added;
    logic [COL_W-1:0]    r_col_limit;

    // packet tracking state
    logic [CHAN_W-1:0]   r_pos;
    logic [15:0]         r_phase;
    logic [31:0]         r_countdown;
    logic [16:0]         r_events;
    logic [COL_W-1:0]    r_cw;
    t_action             r_action;

    // replay sequencer
    t_state              r_state;
    logic [AW-1:0]       r_rep_idx;
    logic [AW-1:0]       r_rep_last;

    // output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [COL_W-1:0]    r_out_col;
    logic                r_out_end;
    logic                r_out_rep;

    logic [SAMPLE_W-1:0] w_rdata;

    // effective channel count and skip factor
    logic [5:0]          w_n;
    logic [15:0]         w_skip;
    logic                w_last;
    logic                w_first;
    // correction decision
    logic                w_neg;
    logic [16:0]         w_mag;
    logic                w_corr;
    logic                w_fire;
    t_action             w_dec_action;
    t_action             w_action;
    // handshakes
    logic                w_out_free;
    logic                w_in_acc;
    logic                w_keep;
    logic [COL_W-1:0]    n_cw;
    logic [16:0]         n_phase_inc;
    logic [15:0]         n_phase;

    always_comb begin
        if (r_num_ch == 6'd0) begin
            w_n = 6'd1;
        end else if (r_num_ch > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = r_num_ch;
        end
    end

    assign w_skip  = (r_skip == 16'd0) ? 16'd1 : r_skip;
    assign w_last  = ({1'b0, r_pos} + 6'd1) >= w_n;
    assign w_first = (r_pos == '0);

    assign w_neg  = r_added[16];
    assign w_mag  = w_neg ? (17'd0 - r_added) : r_added;
    assign w_corr = (r_gap != 32'd0) && (w_mag != 17'd0) && (r_events < w_mag);
    assign w_fire = w_corr && (r_countdown <= 32'd1);

    // action of a packet, decided on its first sample
    always_comb begin
        if (r_phase != 16'd0) begin
            w_dec_action = ACT_NONE;
        end else if ((w_fire && w_neg) || (r_cw >= r_col_limit)) begin
            w_dec_action = ACT_NONE;
        end else if (w_fire) begin
            w_dec_action = ACT_TWICE;
        end else begin
            w_dec_action = ACT_EMIT;
        end
    end

    assign w_action = w_first ? w_dec_action : r_action;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != ST_RUN) || !w_out_free;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_keep     = (w_action != ACT_NONE);

    assign n_cw        = r_cw + 32'd1;
    assign n_phase_inc = {1'b0, r_phase} + 17'd1;
    assign n_phase     = (n_phase_inc >= {1'b0, w_skip}) ? 16'd0 : n_phase_inc[15:0];

    // kept samples are written as they pass; a replay reads them back in order
    pdda_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_replay_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_keep),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_sample_in),
        .i_re    (r_state == ST_READ),
        .i_raddr (r_rep_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch    <= 6'd1;
            r_skip      <= 16'd1;
            r_gap       <= 32'd0;
            r_added     <= 17'd0;
            r_col_limit <= '1;
            r_pos       <= '0;
            r_phase     <= 16'd0;
            r_countdown <= 32'd0;
            r_events    <= 17'd0;
            r_cw        <= '0;
            r_action    <= ACT_NONE;
            r_state     <= ST_RUN;
            r_rep_idx   <= '0;
            r_rep_last  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains on a transfer unless refilled below
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // the user must write configuration only while idle; the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_CHANNELS:  r_num_ch <= i_cfg_data[5:0];
                    CFG_SKIP_FACTOR:   r_skip <= i_cfg_data[15:0];
                    CFG_GAP_INTERVAL: begin
                        r_gap       <= i_cfg_data;
                        r_countdown <= i_cfg_data;
                    end
                    CFG_ADDED_SAMPLES: r_added <= i_cfg_data[16:0];
                    CFG_COLUMN_LIMIT:  r_col_limit <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_RUN: begin
                    if (w_in_acc) begin
                        if (w_first) begin
                            r_action <= w_dec_action;
                            // correction countdown runs only on packets at decimation phase zero
                            if (r_phase == 16'd0 && w_corr) begin
                                if (w_fire) begin
                                    r_countdown <= r_gap;
                                    r_events    <= r_events + 17'd1;
                                end else begin
                                    r_countdown <= r_countdown - 32'd1;
                                end
                            end
                        end
                        if (w_keep) begin
                            r_out_valid  <= 1'b1;
                            r_out_sample <= i_sample_in;
                            r_out_chan   <= r_pos;
                            r_out_col    <= r_cw;
                            r_out_end    <= w_last;
                            r_out_rep    <= 1'b0;
                        end
                        if (w_last) begin
                            if (w_keep) begin
                                r_cw <= n_cw;
                            end
                            // the copy goes out only if its column is still under the limit
                            if (w_action == ACT_TWICE && n_cw < r_col_limit) begin
                                r_state    <= ST_READ;
                                r_rep_idx  <= '0;
                                r_rep_last <= r_pos[AW-1:0];
                            end
                            r_pos   <= '0;
                            r_phase <= n_phase;
                        end else begin
                            r_pos <= r_pos + 5'd1;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    // read data holds in the ram until the output register frees up
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= w_rdata;
                        r_out_chan   <= CHAN_W'(r_rep_idx);
                        r_out_col    <= r_cw;
                        r_out_end    <= (r_rep_idx == r_rep_last);
                        r_out_rep    <= 1'b1;
                        if (r_rep_idx == r_rep_last) begin
                            r_state <= ST_RUN;
                            r_cw    <= n_cw;
                        end else begin
                            r_rep_idx <= r_rep_idx + 1'b1;
                            r_state   <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_channel_out = r_out_chan;
    assign o_column_out  = r_out_col;
    assign o_column_end  = r_out_end;
    assign o_repeated    = r_out_rep;

`include "packet_decimate_drift_align_top_assert.svh"

    // a replay only runs for a packet marked to go out twice
    `PDDA_ASSERT_IMP(a_replay_twice, r_state != ST_RUN, r_action == ACT_TWICE, "replay without repeat action")
    // a free output slot during load always takes a copy sample
    `PDDA_ASSERT_NXT(a_load_fills, r_state == ST_LOAD && !r_out_valid, o_valid && o_repeated, "replay load lost")
    // the last copy sample closes the column and returns to input
    `PDDA_ASSERT_NXT(a_replay_end, r_state == ST_LOAD && w_out_free && r_rep_idx == r_rep_last, r_state == ST_RUN && o_column_end && o_repeated, "replay end wrong")

endmodule
`default_nettype wire
